// File: hw/rtl/ffra_pkg.sv
// Shared types, codes and helper functions of the first-fit range allocator.
package ffra_pkg;

    localparam int DEF_NUM_HEAPS       = 8;
    localparam int DEF_RANGES_PER_HEAP = 16;
    localparam int DEF_RECORD_SLOTS    = 32;

    localparam logic [16:0] HEAP_SIZE_RST = 17'd4096;
    localparam logic [16:0] HEAP_SIZE_MAX = 17'd65536;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_HEAP    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN    = 3'd2;
    localparam logic [2:0] ST_RANGE_FULL = 3'd3;
    localparam logic [2:0] ST_REC_FULL   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REC,
        S_RNG,
        S_DECIDE,
        S_SPLIT,
        S_ACT,
        S_DONE
    } t_state;

    // The highest set bit of the alignment wins; zero acts as one byte.
    function automatic logic [7:0] align_mask(input logic [8:0] a);
        logic [7:0] m;
        m = 8'd0;
        for (int i = 0; i < 9; i++) begin
            if (a[i]) begin
                m = 8'((9'd1 << i) - 9'd1);
            end
        end
        return m;
    endfunction

    function automatic logic [16:0] eff_heap_size(input logic [16:0] hs);
        logic [16:0] v;
        v = hs;
        if (hs == 17'd0) begin
            v = 17'd1;
        end else if (hs > HEAP_SIZE_MAX) begin
            v = HEAP_SIZE_MAX;
        end
        return v;
    endfunction

endpackage

// File: hw/rtl/first_fit_range_allocator_top.sv
// Top level of the first-fit range allocator with its scan sequencer and tables.

// Each request either allocates (tuser 0) or frees (tuser 1) and yields exactly one
// result. The block handles one request at a time; s_axis_tready is high only while it is
// idle. A request first walks the record table, one entry per cycle through a registered
// memory read, stopping at the first free slot (allocate) or the matching record (free).
// An allocate then walks the free-range slots of the active heaps in order until one
// holds a fitting range, with one shared align, fit and compare unit; a free walks only
// the slots of its own heap. The tables are updated in the deciding state, also in the
// split state when a range is cut in two, or in S_ACT when a heap is opened, and S_DONE
// then loads the result register. The result register lets the next request be accepted
// while a result still waits on the master side. Valid bits of both tables are cleared
// by reset at once, so the block is ready right after reset. The heap size register may
// be written at any time the block is idle; it takes effect when a new heap is opened.
module first_fit_range_allocator_top #(
    parameter int NUM_HEAPS       = ffra_pkg::DEF_NUM_HEAPS,
    parameter int RANGES_PER_HEAP = ffra_pkg::DEF_RANGES_PER_HEAP,
    parameter int RECORD_SLOTS    = ffra_pkg::DEF_RECORD_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [16:0] i_cfg_wr_data,    // heap_size
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // heap_index[2:0], offset[18:3], desc_size[31:19], alignment[40:32], zero fill
    input  logic [47:0] i_s_axis_tdata,
    input  logic        i_s_axis_tuser,   // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // out_heap[2:0], out_offset[18:3], zero fill
    output logic [3:0]  o_m_axis_tuser    // status[2:0], new_heap[3]
);

    localparam int HW    = (NUM_HEAPS > 1) ? $clog2(NUM_HEAPS) : 1;
    localparam int SW    = $clog2(RANGES_PER_HEAP);
    localparam int NSLOT = NUM_HEAPS * RANGES_PER_HEAP;
    localparam int AW    = $clog2(NSLOT);
    localparam int RW    = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
    localparam int CW    = ((SW > RW) ? SW : RW) + 1;
    localparam int ACW   = $clog2(NUM_HEAPS + 1);

    // Free ranges: {start, end}. Records: {heap, offset, size}.
    logic [33:0] rng_mem [NSLOT];
    logic [31:0] rec_mem [RECORD_SLOTS];
    logic [33:0] r_rng_q;
    logic [31:0] r_rec_q;
    logic [NSLOT-1:0]        r_rngv;
    logic [RECORD_SLOTS-1:0] r_recv;

    ffra_pkg::t_state r_state, n_state;
    logic [ACW-1:0] r_active, n_active;
    logic [16:0]    r_hs;

    // Request and scan registers.
    logic           r_cmd, n_cmd;
    logic [2:0]     r_fheap, n_fheap;
    logic [15:0]    r_off, n_off;
    logic [12:0]    r_size, n_size;
    logic [7:0]     r_mask, n_mask;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_chk_vld, n_chk_vld;
    logic [CW-1:0]  r_chk_idx, n_chk_idx;
    logic [RW-1:0]  r_rec_idx, n_rec_idx;
    logic [HW-1:0]  r_cur_heap, n_cur_heap;
    logic           r_best_vld, n_best_vld;
    logic [SW-1:0]  r_best_slot, n_best_slot;
    logic [16:0]    r_best_start, n_best_start;
    logic [16:0]    r_best_end, n_best_end;
    logic [16:0]    r_best_al, n_best_al;
    logic           r_emp_vld, n_emp_vld;
    logic [SW-1:0]  r_emp_slot, n_emp_slot;
    logic           r_prev_vld, n_prev_vld;
    logic [SW-1:0]  r_prev_slot, n_prev_slot;
    logic [16:0]    r_prev_start, n_prev_start;
    logic           r_next_vld, n_next_vld;
    logic [SW-1:0]  r_next_slot, n_next_slot;
    logic [16:0]    r_next_end, n_next_end;

    // Pending result and output register.
    logic [2:0]     r_res_status, n_res_status;
    logic [2:0]     r_res_heap, n_res_heap;
    logic [15:0]    r_res_off, n_res_off;
    logic           r_res_new, n_res_new;
    logic           r_out_vld, n_out_vld;
    logic [2:0]     r_out_status, n_out_status;
    logic [2:0]     r_out_heap, n_out_heap;
    logic [15:0]    r_out_off, n_out_off;
    logic           r_out_new, n_out_new;

    // Table write controls.
    logic           rng_we;
    logic [AW-1:0]  rng_waddr;
    logic [33:0]    rng_wdata;
    logic [AW-1:0]  rng_raddr;
    logic           rec_we;
    logic [31:0]    rec_wdata;
    logic [RW-1:0]  rec_raddr;
    logic           rv_set, rv_clr, rv_grp_clr;
    logic [AW-1:0]  rv_set_addr, rv_clr_addr;
    logic [HW-1:0]  rv_grp_heap;
    logic           recv_set, recv_clr;

    // Scan pipeline and shared compare unit.
    logic           in_acc;
    logic [CW-1:0]  limit;
    logic           issue;
    logic [AW-1:0]  hbase;
    logic [RW-1:0]  chk_ridx;
    logic [SW-1:0]  chk_slot;
    logic [AW-1:0]  chk_addr;
    logic [16:0]    cst, cen;
    logic [17:0]    al18;
    logic           fit;
    logic           rec_hit;
    logic [16:0]    ae, fe, hs_eff;
    logic [HW-1:0]  act_heap;
    logic [AW-1:0]  act_base;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ffra_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'd0, r_out_off, r_out_heap};
    assign o_m_axis_tuser  = {r_out_new, r_out_status};

    assign limit  = (r_state == ffra_pkg::S_REC) ? CW'(RECORD_SLOTS) : CW'(RANGES_PER_HEAP);
    assign issue  = ((r_state == ffra_pkg::S_REC) || (r_state == ffra_pkg::S_RNG))
                    && (r_cnt != limit);
    assign hbase  = AW'(r_cur_heap) * AW'(RANGES_PER_HEAP);
    assign rng_raddr = (issue && r_state == ffra_pkg::S_RNG) ? hbase + AW'(r_cnt[SW-1:0])
                                                             : '0;
    assign rec_raddr = (issue && r_state == ffra_pkg::S_REC) ? r_cnt[RW-1:0] : '0;

    assign chk_ridx = r_chk_idx[RW-1:0];
    assign chk_slot = r_chk_idx[SW-1:0];
    assign chk_addr = hbase + AW'(chk_slot);
    assign cst      = r_rng_q[33:17];
    assign cen      = r_rng_q[16:0];
    assign al18     = (18'(cst) + 18'(r_mask)) & ~18'(r_mask);
    assign fit      = (19'(al18) + 19'(r_size)) <= 19'(cen);
    assign rec_hit  = (r_cmd == ffra_pkg::CMD_ALLOC) ? !r_recv[chk_ridx]
                    : (r_recv[chk_ridx] && r_rec_q[31:29] == r_fheap
                       && r_rec_q[28:13] == r_off);
    assign ae       = 17'(r_best_al + 17'(r_size));
    assign fe       = 17'(r_off) + 17'(r_size);
    assign hs_eff   = ffra_pkg::eff_heap_size(r_hs);
    assign act_heap = r_active[HW-1:0];
    assign act_base = AW'(act_heap) * AW'(RANGES_PER_HEAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffra_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_cmd        = r_cmd;
        n_fheap      = r_fheap;
        n_off        = r_off;
        n_size       = r_size;
        n_mask       = r_mask;
        n_cnt        = r_cnt;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_rec_idx    = r_rec_idx;
        n_cur_heap   = r_cur_heap;
        n_best_vld   = r_best_vld;
        n_best_slot  = r_best_slot;
        n_best_start = r_best_start;
        n_best_end   = r_best_end;
        n_best_al    = r_best_al;
        n_emp_vld    = r_emp_vld;
        n_emp_slot   = r_emp_slot;
        n_prev_vld   = r_prev_vld;
        n_prev_slot  = r_prev_slot;
        n_prev_start = r_prev_start;
        n_next_vld   = r_next_vld;
        n_next_slot  = r_next_slot;
        n_next_end   = r_next_end;
        n_res_status = r_res_status;
        n_res_heap   = r_res_heap;
        n_res_off    = r_res_off;
        n_res_new    = r_res_new;
        n_out_vld    = r_out_vld;
        n_out_status = r_out_status;
        n_out_heap   = r_out_heap;
        n_out_off    = r_out_off;
        n_out_new    = r_out_new;
        rng_we       = 1'b0;
        rng_waddr    = '0;
        rng_wdata    = '0;
        rec_we       = 1'b0;
        rec_wdata    = '0;
        rv_set       = 1'b0;
        rv_set_addr  = '0;
        rv_clr       = 1'b0;
        rv_clr_addr  = '0;
        rv_grp_clr   = 1'b0;
        rv_grp_heap  = '0;
        recv_set     = 1'b0;
        recv_clr     = 1'b0;

        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ffra_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_cmd     = i_s_axis_tuser;
                    n_fheap   = i_s_axis_tdata[2:0];
                    n_off     = i_s_axis_tdata[18:3];
                    n_size    = (i_s_axis_tdata[31:19] == 13'd0) ? 13'd1
                                                                 : i_s_axis_tdata[31:19];
                    n_mask    = ffra_pkg::align_mask(i_s_axis_tdata[40:32]);
                    n_cnt     = '0;
                    n_chk_vld = 1'b0;
                    n_state   = ffra_pkg::S_REC;
                end
            end
            ffra_pkg::S_REC: begin
                n_chk_vld = issue;
                n_chk_idx = r_cnt;
                if (issue) begin
                    n_cnt = r_cnt + CW'(1);
                end
                if (r_chk_vld && rec_hit) begin
                    n_rec_idx  = chk_ridx;
                    n_cnt      = '0;
                    n_chk_vld  = 1'b0;
                    n_best_vld = 1'b0;
                    n_emp_vld  = 1'b0;
                    n_prev_vld = 1'b0;
                    n_next_vld = 1'b0;
                    if (r_cmd == ffra_pkg::CMD_FREE) begin
                        // Records only ever name active heaps, so the index fits.
                        n_size     = r_rec_q[12:0];
                        n_cur_heap = r_fheap[HW-1:0];
                        n_state    = ffra_pkg::S_RNG;
                    end else if (r_active == '0) begin
                        n_state = ffra_pkg::S_ACT;
                    end else begin
                        n_cur_heap = '0;
                        n_state    = ffra_pkg::S_RNG;
                    end
                end else if (!issue && !r_chk_vld) begin
                    n_res_status = (r_cmd == ffra_pkg::CMD_ALLOC) ? ffra_pkg::ST_REC_FULL
                                                                  : ffra_pkg::ST_UNKNOWN;
                    n_res_heap   = 3'd0;
                    n_res_off    = 16'd0;
                    n_res_new    = 1'b0;
                    n_state      = ffra_pkg::S_DONE;
                end
            end
            ffra_pkg::S_RNG: begin
                n_chk_vld = issue;
                n_chk_idx = r_cnt;
                if (issue) begin
                    n_cnt = r_cnt + CW'(1);
                end
                if (r_chk_vld) begin
                    if (!r_rngv[chk_addr]) begin
                        if (!r_emp_vld) begin
                            n_emp_vld  = 1'b1;
                            n_emp_slot = chk_slot;
                        end
                    end else if (r_cmd == ffra_pkg::CMD_ALLOC) begin
                        if (fit && (!r_best_vld || cst < r_best_start)) begin
                            n_best_vld   = 1'b1;
                            n_best_slot  = chk_slot;
                            n_best_start = cst;
                            n_best_end   = cen;
                            n_best_al    = al18[16:0];
                        end
                    end else begin
                        if (cen == 17'(r_off) && !r_prev_vld) begin
                            n_prev_vld   = 1'b1;
                            n_prev_slot  = chk_slot;
                            n_prev_start = cst;
                        end else if (cst == fe && !r_next_vld) begin
                            n_next_vld  = 1'b1;
                            n_next_slot = chk_slot;
                            n_next_end  = cen;
                        end
                    end
                end
                if (!issue && !r_chk_vld) begin
                    n_state = ffra_pkg::S_DECIDE;
                end
            end
            ffra_pkg::S_DECIDE: begin
                if (r_cmd == ffra_pkg::CMD_ALLOC) begin
                    if (r_best_vld) begin
                        rec_wdata    = {3'(r_cur_heap), r_best_al[15:0], r_size};
                        n_res_status = ffra_pkg::ST_OK;
                        n_res_heap   = 3'(r_cur_heap);
                        n_res_off    = r_best_al[15:0];
                        n_res_new    = 1'b0;
                        n_state      = ffra_pkg::S_DONE;
                        rng_waddr    = hbase + AW'(r_best_slot);
                        if (r_best_al != r_best_start && ae != r_best_end) begin
                            // Gaps on both sides: the tail needs an empty slot.
                            if (r_emp_vld) begin
                                rng_we    = 1'b1;
                                rng_wdata = {r_best_start, r_best_al};
                                n_state   = ffra_pkg::S_SPLIT;
                            end else begin
                                n_res_status = ffra_pkg::ST_RANGE_FULL;
                                n_res_heap   = 3'd0;
                                n_res_off    = 16'd0;
                            end
                        end else begin
                            rec_we   = 1'b1;
                            recv_set = 1'b1;
                            if (r_best_al != r_best_start) begin
                                rng_we    = 1'b1;
                                rng_wdata = {r_best_start, r_best_al};
                            end else if (ae != r_best_end) begin
                                rng_we    = 1'b1;
                                rng_wdata = {ae, r_best_end};
                            end else begin
                                rv_clr      = 1'b1;
                                rv_clr_addr = hbase + AW'(r_best_slot);
                            end
                        end
                    end else if (ACW'(r_cur_heap) + ACW'(1) < r_active) begin
                        n_cur_heap = r_cur_heap + HW'(1);
                        n_cnt      = '0;
                        n_chk_vld  = 1'b0;
                        n_emp_vld  = 1'b0;
                        n_state    = ffra_pkg::S_RNG;
                    end else begin
                        n_state = ffra_pkg::S_ACT;
                    end
                end else begin
                    n_res_status = ffra_pkg::ST_OK;
                    n_res_heap   = r_fheap;
                    n_res_off    = r_off;
                    n_res_new    = 1'b0;
                    n_state      = ffra_pkg::S_DONE;
                    recv_clr     = 1'b1;
                    rng_we       = 1'b1;
                    if (r_prev_vld && r_next_vld) begin
                        rng_waddr   = hbase + AW'(r_prev_slot);
                        rng_wdata   = {r_prev_start, r_next_end};
                        rv_clr      = 1'b1;
                        rv_clr_addr = hbase + AW'(r_next_slot);
                    end else if (r_prev_vld) begin
                        rng_waddr = hbase + AW'(r_prev_slot);
                        rng_wdata = {r_prev_start, fe};
                    end else if (r_next_vld) begin
                        rng_waddr = hbase + AW'(r_next_slot);
                        rng_wdata = {17'(r_off), r_next_end};
                    end else if (r_emp_vld) begin
                        rng_waddr   = hbase + AW'(r_emp_slot);
                        rng_wdata   = {17'(r_off), fe};
                        rv_set      = 1'b1;
                        rv_set_addr = hbase + AW'(r_emp_slot);
                    end else begin
                        rng_we       = 1'b0;
                        recv_clr     = 1'b0;
                        n_res_status = ffra_pkg::ST_RANGE_FULL;
                        n_res_heap   = 3'd0;
                        n_res_off    = 16'd0;
                    end
                end
            end
            ffra_pkg::S_SPLIT: begin
                rng_we       = 1'b1;
                rng_waddr    = hbase + AW'(r_emp_slot);
                rng_wdata    = {ae, r_best_end};
                rv_set       = 1'b1;
                rv_set_addr  = hbase + AW'(r_emp_slot);
                rec_we       = 1'b1;
                rec_wdata    = {3'(r_cur_heap), r_best_al[15:0], r_size};
                recv_set     = 1'b1;
                n_res_status = ffra_pkg::ST_OK;
                n_res_heap   = 3'(r_cur_heap);
                n_res_off    = r_best_al[15:0];
                n_res_new    = 1'b0;
                n_state      = ffra_pkg::S_DONE;
            end
            ffra_pkg::S_ACT: begin
                n_res_heap = 3'd0;
                n_res_off  = 16'd0;
                n_res_new  = 1'b0;
                n_state    = ffra_pkg::S_DONE;
                if (r_active >= ACW'(NUM_HEAPS) || 17'(r_size) > hs_eff) begin
                    n_res_status = ffra_pkg::ST_NO_HEAP;
                end else begin
                    rv_grp_clr = 1'b1;
                    rv_grp_heap = act_heap;
                    if (17'(r_size) < hs_eff) begin
                        rng_we      = 1'b1;
                        rng_waddr   = act_base;
                        rng_wdata   = {17'(r_size), hs_eff};
                        rv_set      = 1'b1;
                        rv_set_addr = act_base;
                    end
                    n_active     = r_active + ACW'(1);
                    rec_we       = 1'b1;
                    rec_wdata    = {3'(act_heap), 16'd0, r_size};
                    recv_set     = 1'b1;
                    n_res_status = ffra_pkg::ST_OK;
                    n_res_heap   = 3'(act_heap);
                    n_res_new    = 1'b1;
                end
            end
            ffra_pkg::S_DONE: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_heap   = r_res_heap;
                    n_out_off    = r_res_off;
                    n_out_new    = r_res_new;
                    n_state      = ffra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffra_pkg::S_IDLE;
            end
        endcase
    end

    // Control state, configuration and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_hs      <= ffra_pkg::HEAP_SIZE_RST;
            r_out_vld <= 1'b0;
            r_rngv    <= '0;
            r_recv    <= '0;
        end else begin
            r_active  <= n_active;
            r_out_vld <= n_out_vld;
            if (i_cfg_wr_en) begin
                r_hs <= i_cfg_wr_data;
            end
            if (rv_grp_clr) begin
                // Opening a heap clears its slots; the first may take the leftover range.
                for (int r = 0; r < RANGES_PER_HEAP; r++) begin
                    r_rngv[AW'(rv_grp_heap) * AW'(RANGES_PER_HEAP) + AW'(r)] <=
                        (r == 0) && rv_set;
                end
            end else begin
                if (rv_clr) begin
                    r_rngv[rv_clr_addr] <= 1'b0;
                end
                if (rv_set) begin
                    r_rngv[rv_set_addr] <= 1'b1;
                end
            end
            if (recv_set) begin
                r_recv[r_rec_idx] <= 1'b1;
            end
            if (recv_clr) begin
                r_recv[r_rec_idx] <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_fheap      <= n_fheap;
        r_off        <= n_off;
        r_size       <= n_size;
        r_mask       <= n_mask;
        r_cnt        <= n_cnt;
        r_chk_vld    <= n_chk_vld;
        r_chk_idx    <= n_chk_idx;
        r_rec_idx    <= n_rec_idx;
        r_cur_heap   <= n_cur_heap;
        r_best_vld   <= n_best_vld;
        r_best_slot  <= n_best_slot;
        r_best_start <= n_best_start;
        r_best_end   <= n_best_end;
        r_best_al    <= n_best_al;
        r_emp_vld    <= n_emp_vld;
        r_emp_slot   <= n_emp_slot;
        r_prev_vld   <= n_prev_vld;
        r_prev_slot  <= n_prev_slot;
        r_prev_start <= n_prev_start;
        r_next_vld   <= n_next_vld;
        r_next_slot  <= n_next_slot;
        r_next_end   <= n_next_end;
        r_res_status <= n_res_status;
        r_res_heap   <= n_res_heap;
        r_res_off    <= n_res_off;
        r_res_new    <= n_res_new;
        r_out_status <= n_out_status;
        r_out_heap   <= n_out_heap;
        r_out_off    <= n_out_off;
        r_out_new    <= n_out_new;
    end

    // Range and record memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (rng_we) begin
            rng_mem[rng_waddr] <= rng_wdata;
        end
        r_rng_q <= rng_mem[rng_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            rec_mem[r_rec_idx] <= rec_wdata;
        end
        r_rec_q <= rec_mem[rec_raddr];
    end

endmodule

// File: hw/rtl/ffra_checker.sv
// Port-level checker of the first-fit range allocator and its bind.
module ffra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [3:0]  o_m_axis_tuser
);

    // A result waiting on the master side holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // An accepted request keeps the block busy for the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request accepted while busy");

    // A failed request reports no heap, no offset and no new heap.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2:0] != ffra_pkg::ST_OK |->
            o_m_axis_tdata == 24'd0 && !o_m_axis_tuser[3])
        else $error("failure result carries data");

    // A freshly opened heap always hands out its offset zero.
    a_new_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[3] |->
            o_m_axis_tuser[2:0] == ffra_pkg::ST_OK && o_m_axis_tdata[18:3] == 16'd0)
        else $error("new heap result not at offset zero");

endmodule

bind first_fit_range_allocator_top ffra_checker u_ffra_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
